// File: rtl/pgr_pkg.sv
package pgr_pkg;

	localparam int DISP_COLS = 160;
	localparam int DISP_ROWS = 100;

	localparam int FONT_BYTES = 1152;
	localparam int FONT_AW = $clog2(FONT_BYTES);
	localparam logic [FONT_AW-1:0] ADVANCE_BASE = FONT_AW'(1024);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	typedef struct packed {
		logic operation;
		logic [10:0] font_address;
		logic [7:0] font_data;
		logic [7:0] character;
		logic [3:0] pen_color;
		logic start_of_text;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
	} item_t;

	typedef struct packed {
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic [3:0] pixel_color;
		logic last_pixel;
	} pixel_t;

	typedef logic [2:0] step_t;

	localparam step_t ST_IDLE = 3'd0;
	localparam step_t ST_RDROW = 3'd1;
	localparam step_t ST_LATCH = 3'd2;
	localparam step_t ST_SCAN = 3'd3;
	localparam step_t ST_RDADV = 3'd4;
	localparam step_t ST_FIN = 3'd5;

	typedef enum logic [1:0] {
		JC_NEXT,
		JC_DRAW,
		JC_SCAN,
		JC_FIN
	} jump_t;

	typedef struct packed {
		logic accept;
		logic rd_row;
		logic rd_adv;
		logic latch;
		logic scan;
		logic finish;
		jump_t jump;
		step_t target;
	} ctrl_t;

	function automatic ctrl_t ucode(step_t s);
		ctrl_t c;
		c = '{accept: 1'b0, rd_row: 1'b0, rd_adv: 1'b0, latch: 1'b0, scan: 1'b0,
			finish: 1'b0, jump: JC_NEXT, target: ST_IDLE};
		case (s)
			ST_IDLE: begin
				c.accept = 1'b1;
				c.jump = JC_DRAW;
				c.target = ST_RDROW;
			end
			ST_RDROW: begin
				c.rd_row = 1'b1;
				c.target = ST_LATCH;
			end
			ST_LATCH: begin
				c.latch = 1'b1;
				c.target = ST_SCAN;
			end
			ST_SCAN: begin
				c.scan = 1'b1;
				c.jump = JC_SCAN;
				c.target = ST_RDADV;
			end
			ST_RDADV: begin
				c.rd_adv = 1'b1;
				c.target = ST_FIN;
			end
			ST_FIN: begin
				c.finish = 1'b1;
				c.jump = JC_FIN;
				c.target = ST_IDLE;
			end
			default: begin
				c.target = ST_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// File: rtl/proportional_glyph_rasterizer.sv
// font write: taken in the idle step, which it does not leave, so another item can be taken straight away
// draw: each of the 8 glyph rows takes a read step and a latch step on the single font
// ram read port plus 8 column steps, then an advance read step and a finish step; the
// pixel side can stall the column and finish steps
// output: a pixel leaves at the next hit, the last one at the finish step with last_pixel set
// reset: pen at (0,0), sequencer idle, no pixel pending; font contents undefined
module proportional_glyph_rasterizer
	import pgr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input item_t item,
	output logic pixel_valid,
	input logic pixel_stall,
	output pixel_t pixel
);

	step_t step_q, step_nxt;
	ctrl_t cw;

	logic [6:0] glyph_q;
	logic [3:0] color_q;
	logic signed [15:0] pen_x_q, pen_y_q;
	logic [2:0] row_q, col_q;
	logic [7:0] bits_q;

	pixel_t out_q;
	logic out_v_q;
	pixel_t pend_q;
	logic pend_v_q;

	logic ram_we;
	logic [FONT_AW-1:0] ram_raddr;
	logic [7:0] ram_rdata;

	logic accepted, is_draw, out_free;
	logic signed [16:0] px, py, nx;
	logic hit, hold, fin_ok, col_end;

	assign cw = ucode(step_q);
	assign item_stall = !cw.accept;
	assign accepted = item_valid && cw.accept;
	assign is_draw = accepted && item.operation == OP_DRAW;
	assign ram_we = accepted && item.operation == OP_WRITE
		&& item.font_address < 11'(FONT_BYTES);

	always_comb begin
		ram_raddr = ADVANCE_BASE + FONT_AW'(glyph_q);
		if (cw.rd_row) begin
			ram_raddr = FONT_AW'({glyph_q, row_q});
		end
	end

	pgr_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font (
		.clk(clk),
		.we(ram_we),
		.waddr(item.font_address[FONT_AW-1:0]),
		.wdata(item.font_data),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free = !out_v_q || !pixel_stall;
	assign px = 17'(pen_x_q) + 17'(col_q);
	assign py = 17'(pen_y_q) + 17'(row_q);
	assign hit = bits_q[3'd7 - col_q] && px >= 0 && px < 17'(DISP_COLS)
		&& py >= 0 && py < 17'(DISP_ROWS);
	assign hold = hit && pend_v_q && !out_free;
	assign col_end = col_q == 3'd7;
	assign fin_ok = !pend_v_q || out_free;
	assign nx = 17'(pen_x_q) + 17'({1'b0, ram_rdata});

	always_comb begin
		step_nxt = step_q;
		case (cw.jump)
			JC_NEXT: step_nxt = cw.target;
			JC_DRAW: begin
				if (is_draw) begin
					step_nxt = cw.target;
				end
			end
			JC_SCAN: begin
				if (!hold && col_end) begin
					step_nxt = (row_q == 3'd7) ? cw.target : ST_RDROW;
				end
			end
			JC_FIN: begin
				if (fin_ok) begin
					step_nxt = cw.target;
				end
			end
			default: step_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			pen_x_q <= '0;
			pen_y_q <= '0;
			row_q <= '0;
			col_q <= '0;
			out_v_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			step_q <= step_nxt;
			if (out_v_q && !pixel_stall) begin
				out_v_q <= 1'b0;
			end
			if (is_draw) begin
				row_q <= '0;
				col_q <= '0;
				if (item.start_of_text) begin
					pen_x_q <= item.start_x;
					pen_y_q <= item.start_y;
				end
			end
			if (cw.scan && !hold) begin
				col_q <= col_q + 3'd1;
				if (col_end) begin
					row_q <= row_q + 3'd1;
				end
				if (hit) begin
					pend_v_q <= 1'b1;
					if (pend_v_q) begin
						out_v_q <= 1'b1;
					end
				end
			end
			if (cw.finish && fin_ok) begin
				pend_v_q <= 1'b0;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end
				pen_x_q <= (nx[16] != nx[15]) ? 16'sh7fff : nx[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_draw) begin
			glyph_q <= item.character[6:0];
			color_q <= item.pen_color;
		end
		if (cw.latch) begin
			bits_q <= ram_rdata;
		end
		if (cw.scan && !hold && hit) begin
			pend_q <= '{pixel_x: px[7:0], pixel_y: py[7:0], pixel_color: color_q,
				last_pixel: 1'b0};
			if (pend_v_q) begin
				out_q <= pend_q;
			end
		end
		if (cw.finish && fin_ok && pend_v_q) begin
			out_q <= '{pixel_x: pend_q.pixel_x, pixel_y: pend_q.pixel_y,
				pixel_color: pend_q.pixel_color, last_pixel: 1'b1};
		end
	end

	assign pixel_valid = out_v_q;
	assign pixel = out_q;

endmodule

// File: rtl/pgr_ram.sv
module pgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1152
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: tb/pgr_pixel_checker.sv
module pgr_pixel_checker
	import pgr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input item_t item,
	input logic pixel_valid,
	input logic pixel_stall,
	input pixel_t pixel,
	output int errors,
	output int due,
	output int font_writes,
	output int chars_drawn,
	output int pixels_matched
);

	logic [7:0] font_copy [FONT_BYTES];
	logic signed [15:0] pen_x;
	logic signed [15:0] pen_y;
	pixel_t glyph_pixels [$];

	task automatic rasterize(input item_t it);
		logic [6:0] glyph;
		logic [7:0] bits;
		int row;
		int col;
		int px;
		int py;
		int nx;
		int first;
		pixel_t p;
		if (it.operation == OP_WRITE) begin
			if (it.font_address < FONT_BYTES) begin
				font_copy[it.font_address] = it.font_data;
			end
			font_writes++;
			return;
		end
		chars_drawn++;
		glyph = it.character[6:0];
		if (it.start_of_text) begin
			pen_x = it.start_x;
			pen_y = it.start_y;
		end
		first = glyph_pixels.size();
		for (row = 0; row < 8; row++) begin
			bits = font_copy[{glyph, 3'(row)}];
			for (col = 0; col < 8; col++) begin
				px = int'(pen_x) + col;
				py = int'(pen_y) + row;
				if (bits[7 - col] && px >= 0 && px < DISP_COLS && py >= 0
						&& py < DISP_ROWS) begin
					p.pixel_x = 8'(px);
					p.pixel_y = 8'(py);
					p.pixel_color = it.pen_color;
					p.last_pixel = 1'b0;
					glyph_pixels.push_back(p);
				end
			end
		end
		if (glyph_pixels.size() > first) begin
			p = glyph_pixels[glyph_pixels.size() - 1];
			p.last_pixel = 1'b1;
			glyph_pixels[glyph_pixels.size() - 1] = p;
		end
		// advance width is unsigned, so only the upper limit can be hit
		nx = int'(pen_x) + int'(font_copy[ADVANCE_BASE + 11'(glyph)]);
		if (nx > 32767) begin
			nx = 32767;
		end
		pen_x = 16'(nx);
	endtask

	always @(posedge clk) begin
		pixel_t want;
		if (!arst_n) begin
			pen_x = '0;
			pen_y = '0;
			errors = 0;
			font_writes = 0;
			chars_drawn = 0;
			pixels_matched = 0;
			glyph_pixels.delete();
		end else begin
			if (pixel_valid && !pixel_stall) begin
				if (glyph_pixels.size() == 0) begin
					$error("pixel transaction with none due: x %0d y %0d",
						pixel.pixel_x, pixel.pixel_y);
					errors++;
				end else begin
					want = glyph_pixels.pop_front();
					if (pixel.pixel_x !== want.pixel_x) begin
						$error("pixel_x expected %0d actual %0d", want.pixel_x, pixel.pixel_x);
						errors++;
					end
					if (pixel.pixel_y !== want.pixel_y) begin
						$error("pixel_y expected %0d actual %0d", want.pixel_y, pixel.pixel_y);
						errors++;
					end
					if (pixel.pixel_color !== want.pixel_color) begin
						$error("pixel_color expected %0d actual %0d", want.pixel_color,
							pixel.pixel_color);
						errors++;
					end
					if (pixel.last_pixel !== want.last_pixel) begin
						$error("last_pixel expected %0b actual %0b", want.last_pixel,
							pixel.last_pixel);
						errors++;
					end
					pixels_matched++;
				end
			end
			if (item_valid && !item_stall) begin
				rasterize(item);
			end
		end
		due = glyph_pixels.size();
	end

endmodule

// File: tb/tb_proportional_glyph_rasterizer.sv
module tb_proportional_glyph_rasterizer;
	import pgr_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic pixel_valid;
	logic pixel_stall;
	pixel_t pixel;

	int errors;
	int due;
	int font_writes;
	int chars_drawn;
	int pixels_matched;

	int items_sent = 0;
	bit hold_go = 1'b0;
	bit calm = 1'b0;
	logic [6:0] loaded [$];

	always #1 clk = ~clk;

	proportional_glyph_rasterizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel)
	);

	pgr_pixel_checker pixel_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.errors(errors),
		.due(due),
		.font_writes(font_writes),
		.chars_drawn(chars_drawn),
		.pixels_matched(pixels_matched)
	);

	function automatic item_t random_item();
		item_t it;
		it.operation = 1'($urandom);
		it.font_address = 11'($urandom);
		it.font_data = 8'($urandom);
		it.character = 8'($urandom);
		it.pen_color = 4'($urandom);
		it.start_of_text = 1'($urandom);
		it.start_x = 16'($urandom);
		it.start_y = 16'($urandom);
		return it;
	endfunction

	function automatic logic [7:0] pick_char();
		return {1'($urandom), loaded[$urandom_range(0, loaded.size() - 1)]};
	endfunction

	task automatic send(input item_t it);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic write_font(input int addr, input logic [7:0] data);
		item_t it;
		it = random_item();
		it.operation = OP_WRITE;
		it.font_address = 11'(addr);
		it.font_data = data;
		send(it);
	endtask

	// fill below zero means random rows
	task automatic load_glyph(input logic [6:0] g, input int fill, input logic [7:0] adv);
		int row;
		logic [7:0] bits;
		for (row = 0; row < 8; row++) begin
			bits = (fill < 0) ? 8'($urandom) : 8'(fill);
			write_font({g, 3'(row)}, bits);
		end
		write_font(int'(ADVANCE_BASE) + g, adv);
		loaded.push_back(g);
	endtask

	task automatic draw(input logic [7:0] ch, input logic [3:0] color, input logic sot,
			input int x, input int y);
		item_t it;
		it = random_item();
		it.operation = OP_DRAW;
		it.character = ch;
		it.pen_color = color;
		it.start_of_text = sot;
		it.start_x = 16'(x);
		it.start_y = 16'(y);
		send(it);
	endtask

	// pixel side: random stall bursts plus one long hold-off
	initial begin
		int burst;
		int hold;
		bit held;
		burst = 0;
		hold = 0;
		held = 1'b0;
		pixel_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				pixel_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				pixel_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(0, 9);
				pixel_stall <= 1'b1;
			end else begin
				pixel_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int roll;
		int run_len;
		int k;
		int sx;
		int sy;
		int wait_cycles;
		logic [7:0] adv;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// full glyph, blank glyph, out-of-range write, clipping and pen saturation
		load_glyph(7'h7F, 8'hFF, 8'd255);
		load_glyph(7'h00, 0, 8'd8);
		write_font(2047, 8'h00);
		draw(8'hFF, 4'hF, 1'b1, 0, 0);
		draw(8'h00, 4'h0, 1'b1, -32768, -32768);
		draw(8'h7F, 4'h5, 1'b0, 0, 0);
		draw(8'h7F, 4'h9, 1'b1, -4, -4);
		draw(8'h7F, 4'hA, 1'b1, DISP_COLS - 4, DISP_ROWS - 4);
		draw(8'h7F, 4'h3, 1'b1, 32767 - 100, 32767);
		draw(8'hFF, 4'hC, 1'b0, 0, 0);

		while (items_sent < 180) begin
			if (items_sent >= 70) begin
				hold_go = 1'b1;
			end
			if (items_sent >= 155) begin
				calm = 1'b1;
			end
			roll = $urandom_range(0, 9);
			if (roll == 0) begin
				adv = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(200, 255))
					: 8'($urandom_range(0, 9));
				load_glyph(7'($urandom), -1, adv);
			end else if (roll == 1) begin
				if ($urandom_range(0, 4) == 0) begin
					write_font($urandom_range(FONT_BYTES, 2047), 8'($urandom));
				end else begin
					write_font($urandom_range(0, FONT_BYTES - 1), 8'($urandom));
				end
			end else begin
				roll = $urandom_range(0, 9);
				if (roll < 7) begin
					sx = $urandom_range(0, DISP_COLS + 16) - 8;
				end else if (roll == 7) begin
					sx = 32767 - $urandom_range(0, 300);
				end else begin
					sx = $urandom_range(0, 65535) - 32768;
				end
				if ($urandom_range(0, 4) != 0) begin
					sy = $urandom_range(0, DISP_ROWS + 16) - 8;
				end else begin
					sy = $urandom_range(0, 65535) - 32768;
				end
				run_len = $urandom_range(1, 6);
				draw(pick_char(), 4'($urandom), $urandom_range(0, 9) != 0, sx, sy);
				for (k = 1; k < run_len; k++) begin
					if ($urandom_range(0, 9) == 0) begin
						write_font($urandom_range(0, FONT_BYTES - 1), 8'($urandom));
					end
					draw(pick_char(), 4'($urandom), 1'b0, $urandom, $urandom);
				end
			end
		end

		calm = 1'b1;
		item_valid <= 1'b0;
		@(posedge clk);
		wait_cycles = 0;
		while (due != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);
		if (due != 0) begin
			$error("%0d pixel transactions never arrived", due);
		end
		$display("covered %0d font writes and %0d characters, %0d pixel transactions checked",
			font_writes, chars_drawn, pixels_matched);
		$display("including clipping on all edges, pen saturation and a long pixel hold-off");
		if (errors == 0 && due == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
